[rtl/speed_pi_loop_filtered_macros.svh]
// Assertion macros for the speed PI loop block.
// Define ASSERT_OFF to compile every assertion out; no other dependencies.
`ifndef SPEED_PI_LOOP_FILTERED_MACROS_SVH
`define SPEED_PI_LOOP_FILTERED_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property checked on every rising edge outside reset
`define SPF_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Consequent checked in the cycle after the antecedent
`define SPF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SPF_ASSERT(lbl, ck, rn, prop, msg)
`define SPF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[rtl/spf_pkg.sv]
// Shared types and constants of the speed PI loop block.
// No dependencies; used by spf_regs and speed_pi_loop_filtered.
package spf_pkg;

    // Fixed point: 8 fraction bits, filter 0.7/0.3 in Q8
    localparam int unsigned FRAC_BITS = 8;
    localparam logic signed [8:0] FILT_OLD_COEF = 9'sd179;
    localparam logic signed [8:0] FILT_NEW_COEF = 9'sd77;

    // Output saturation bounds
    localparam int unsigned OUT_W = 24;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    // Configuration port geometry
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_INTEG_LIMIT = 3'd2,
        REG_TILT_LIMIT  = 3'd3,
        REG_DRIVE_STEP  = 3'd4
    } reg_idx_t;

    // Reset values
    localparam logic [15:0] PROP_GAIN_RST   = 16'd25600;
    localparam logic [15:0] INTEG_GAIN_RST  = 16'd128;
    localparam logic [15:0] INTEG_LIMIT_RST = 16'd10000;
    localparam logic [7:0]  TILT_LIMIT_RST  = 8'd40;
    localparam logic [7:0]  DRIVE_STEP_RST  = 8'd20;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] integ_limit;
        logic [7:0]  tilt_limit;
        logic [7:0]  drive_step;
    } spf_cfg_t;

endpackage

[rtl/speed_pi_loop_filtered.sv]
// Top level of the speed PI loop: low-pass filter, clamped integral, PI output.
// Depends on spf_pkg, spf_regs and speed_pi_loop_filtered_macros.svh.
//
// Usage:
//   One input beat per control tick on s_tvalid/s_tready/s_tdata carries
//   left_count, right_count, pitch_deg, fwd_cmd and back_cmd. One result
//   beat per input on m_tvalid/m_tready/m_tdata carries drive_out.
//   Gains and limits sit in the APB register file; write them while idle.
// Stages and throughput:
//   Five register stages (input, filter, integral, products, output). One
//   beat per cycle is accepted while no stall holds the pipeline; the
//   filter and integral recurrences each close in a single stage, which
//   sets that rate.
// Reset:
//   Filtered speed and integral clear to zero, registers take their
//   defaults, all stage valids clear.
// Stall:
//   Each stage holds while the stage after it is full and stalled, so
//   bubbles are squeezed out and s_tready drops only once every stage holds
//   a beat behind a stalled m_tready.
module speed_pi_loop_filtered #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // s_tdata: left_count, right_count, pitch_deg[8:0], fwd_cmd, back_cmd
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((2*COUNT_BITS+11+7)/8)*8-1:0]      s_tdata,
    // m_tdata: drive_out[23:0]
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [spf_pkg::OUT_W-1:0]                 m_tdata,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [spf_pkg::PADDR_W-1:0]               paddr,
    input  logic [spf_pkg::PDATA_W-1:0]               pwdata,
    output logic [spf_pkg::PDATA_W-1:0]               prdata,
    output logic                                      pready
);
    import spf_pkg::*;

    `include "speed_pi_loop_filtered_macros.svh"

    // State width: room for the filtered sum and for a full integral clamp
    localparam int unsigned SW    = (COUNT_BITS + 10 > 26) ? COUNT_BITS + 10 : 26;
    localparam int unsigned SUM_W = COUNT_BITS + 1;
    localparam int unsigned AW    = SW + 2;
    localparam int unsigned PW    = SW + 17;
    localparam int unsigned TW    = SW + 18;

    spf_cfg_t cfg;

    spf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage enables, walking back from the output register
    logic en_out, en3, en2, en1, en0;
    logic v0_reg, v1_reg, v2_reg, v3_reg, out_valid_reg;

    assign en_out   = !out_valid_reg || m_tready;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;
    assign m_tvalid = out_valid_reg;

    // Stage 0: input register
    logic signed [COUNT_BITS-1:0] left0_reg, right0_reg;
    logic signed [8:0]            pitch0_reg;
    logic                         fwd0_reg, back0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en0)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en0 && s_tvalid)
        begin
            left0_reg  <= s_tdata[COUNT_BITS-1:0];
            right0_reg <= s_tdata[2*COUNT_BITS-1:COUNT_BITS];
            pitch0_reg <= s_tdata[2*COUNT_BITS+8:2*COUNT_BITS];
            fwd0_reg   <= s_tdata[2*COUNT_BITS+9];
            back0_reg  <= s_tdata[2*COUNT_BITS+10];
        end
    end

    // Stage 1: low-pass filter, filt = (179*filt + 77*(sum<<8)) >>> 8
    logic signed [SW-1:0]    filt_reg;
    logic signed [SUM_W-1:0] wheel_sum;
    logic signed [SW-1:0]    sum_q;
    logic signed [SW+8:0]    filt_acc;
    logic signed [SW-1:0]    filt_next;
    logic signed [8:0]       pitch1_reg;
    logic                    fwd1_reg, back1_reg;

    assign wheel_sum = SUM_W'(left0_reg) + SUM_W'(right0_reg);
    assign sum_q     = $signed({{(SW-SUM_W-FRAC_BITS){wheel_sum[SUM_W-1]}},
                                wheel_sum, {FRAC_BITS{1'b0}}});
    assign filt_acc  = (SW+9)'(filt_reg) * (SW+9)'(FILT_OLD_COEF)
                     + (SW+9)'(sum_q) * (SW+9)'(FILT_NEW_COEF);
    assign filt_next = filt_acc[SW+FRAC_BITS-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            filt_reg <= '0;
        end
        else if (en1)
        begin
            v1_reg <= v0_reg;
            if (v0_reg)
                filt_reg <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && v0_reg)
        begin
            pitch1_reg <= pitch0_reg;
            fwd1_reg   <= fwd0_reg;
            back1_reg  <= back0_reg;
        end
    end

    // Stage 2: integral with drive offset, clamp, tilt clear
    logic signed [SW-1:0] integ_reg;
    logic signed [AW-1:0] step_q, lim_q, integ_acc, integ_clamp;
    logic [8:0]           pitch_mag;
    logic                 tilt_trip;
    logic signed [SW-1:0] filt2_reg, integ2_reg;

    assign step_q = $signed(AW'({cfg.drive_step, {FRAC_BITS{1'b0}}}));
    assign lim_q  = $signed(AW'({cfg.integ_limit, {FRAC_BITS{1'b0}}}));

    always_comb
    begin
        integ_acc = AW'(integ_reg) + AW'(filt_reg);
        if (fwd1_reg)
            integ_acc = integ_acc - step_q;
        else if (back1_reg)
            integ_acc = integ_acc + step_q;
        if (integ_acc > lim_q)
            integ_clamp = lim_q;
        else if (integ_acc < -lim_q)
            integ_clamp = -lim_q;
        else
            integ_clamp = integ_acc;
    end

    assign pitch_mag = pitch1_reg[8] ? 9'(-pitch1_reg) : 9'(pitch1_reg);
    assign tilt_trip = pitch_mag > {1'b0, cfg.tilt_limit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            integ_reg <= '0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
            if (v1_reg)
                integ_reg <= tilt_trip ? '0 : integ_clamp[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            filt2_reg  <= filt_reg;
            integ2_reg <= integ_clamp[SW-1:0];
        end
    end

    // Stage 3: gain products, Q16
    logic signed [PW-1:0] prop_prod_reg, integ_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            prop_prod_reg  <= PW'($signed({1'b0, cfg.prop_gain})) * PW'(filt2_reg);
            integ_prod_reg <= PW'($signed({1'b0, cfg.integ_gain})) * PW'(integ2_reg);
        end
    end

    // Stage 4: sum, floor shift by 16, saturate to the output width
    logic signed [TW-1:0]    prod_sum;
    logic signed [AW-1:0]    res_full;
    logic signed [OUT_W-1:0] drive_next;
    logic [OUT_W-1:0]        drive_out_reg;

    assign prod_sum = TW'(prop_prod_reg) + TW'(integ_prod_reg);
    assign res_full = prod_sum[TW-1:2*FRAC_BITS];

    always_comb
    begin
        if (res_full > AW'(OUT_MAX))
            drive_next = OUT_MAX;
        else if (res_full < AW'(OUT_MIN))
            drive_next = OUT_MIN;
        else
            drive_next = res_full[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v3_reg)
            drive_out_reg <= drive_next;
    end

    assign m_tdata = drive_out_reg;

    // Checks
    `SPF_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid_reg |-> s_tready, "stall with empty output")
    `SPF_ASSERT_NEXT(a_integ_in_limit, clk, rst_n, en2 && v1_reg, (integ2_reg <= $past(lim_q)) && (integ2_reg >= -$past(lim_q)), "integral past clamp")
    `SPF_ASSERT_NEXT(a_tilt_clears, clk, rst_n, en2 && v1_reg && tilt_trip, integ_reg == '0, "tilt did not clear integral")
    `SPF_ASSERT_NEXT(a_result_lands, clk, rst_n, v3_reg && en_out, out_valid_reg, "product stage beat lost")

endmodule

[rtl/spf_regs.sv]
// APB-style configuration registers of the speed PI loop block.
// Depends on spf_pkg for the register map, reset values and spf_cfg_t.
module spf_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spf_pkg::PADDR_W-1:0]    paddr,
    input  logic [spf_pkg::PDATA_W-1:0]    pwdata,
    output logic [spf_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output spf_pkg::spf_cfg_t              cfg
);
    import spf_pkg::*;

    spf_cfg_t               cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[PADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Register writes; indexes past the map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain   <= PROP_GAIN_RST;
            cfg_reg.integ_gain  <= INTEG_GAIN_RST;
            cfg_reg.integ_limit <= INTEG_LIMIT_RST;
            cfg_reg.tilt_limit  <= TILT_LIMIT_RST;
            cfg_reg.drive_step  <= DRIVE_STEP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= pwdata[15:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= pwdata[15:0];
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= pwdata[15:0];
                REG_TILT_LIMIT:  cfg_reg.tilt_limit  <= pwdata[7:0];
                REG_DRIVE_STEP:  cfg_reg.drive_step  <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_PROP_GAIN:   prdata = PDATA_W'(cfg_reg.prop_gain);
            REG_INTEG_GAIN:  prdata = PDATA_W'(cfg_reg.integ_gain);
            REG_INTEG_LIMIT: prdata = PDATA_W'(cfg_reg.integ_limit);
            REG_TILT_LIMIT:  prdata = PDATA_W'(cfg_reg.tilt_limit);
            REG_DRIVE_STEP:  prdata = PDATA_W'(cfg_reg.drive_step);
            default:         prdata = '0;
        endcase
    end

endmodule
